### rtl/fwss_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-weight sign sampler package
// Shared widths, coefficient codes and the structs passed between the
// sampler core and the top level.
// ----------------------------------------------------------------------------
package fwss_pkg;

  // Default number of nonzero coefficients in one vector.
  localparam int unsigned WEIGHT_DEFAULT = 60;

  // Field widths of one word.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COEF_W  = 2;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned NUM_POS = 256;

  // Packed output data width, rounded up to whole bytes.
  localparam int unsigned OUT_DATA_W = ((BYTE_W + COEF_W + 7) / 8) * 8;

  // Two's-complement coefficient codes.
  localparam logic signed [COEF_W-1:0] COEF_PLUS  = 2'sb01;
  localparam logic signed [COEF_W-1:0] COEF_MINUS = 2'sb11;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0]        position;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last;
  } result_t;

  // Progress of the current vector.
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } status_t;

endpackage

### rtl/fixed_weight_sign_sampler.sv
// ----------------------------------------------------------------------------
// Fixed-weight sign sampler
// Turns a stream of pseudo-random bytes into WEIGHT distinct positions with
// +1 or -1 coefficients.
// ----------------------------------------------------------------------------
// Each input word is captured in an input register, run through the bitmap
// check and sign selection, and any result lands in an output register, so
// one word can be accepted per clock while the output is not stalled. The
// first (WEIGHT>>3)+1 words of a vector are sign bytes and give no result;
// later words are positions, and a repeated position is dropped. The word
// that completes the vector carries tlast; words after it are dropped until
// one arrives with tuser set, which starts a new vector with that word as
// its first sign byte. After reset the block behaves as if a start had just
// been requested.
module fixed_weight_sign_sampler #(
  parameter int unsigned WEIGHT = fwss_pkg::WEIGHT_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input words.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fwss_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rand_byte
  input  logic                              s_axis_tuser,  // [0] start_req
  // Result words.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fwss_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [7:0] position, [9:8] coefficient
  output logic                              m_axis_tlast   // last
);

  logic                          in_valid;
  logic [fwss_pkg::BYTE_W-1:0]   in_byte;
  logic                          in_start;
  logic                          out_valid;
  fwss_pkg::result_t             out_result;
  logic                          fire;
  logic                          emit;
  fwss_pkg::result_t             result;
  fwss_pkg::status_t             status;

  // The held word moves on when the output register is free or draining.
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  fwss_core #(
    .WEIGHT (WEIGHT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (fire),
    .rand_byte (in_byte),
    .start_req (in_start),
    .emit      (emit),
    .result    (result),
    .status    (status)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(fwss_pkg::OUT_DATA_W - fwss_pkg::BYTE_W - fwss_pkg::COEF_W)'(0),
                          out_result.coefficient, out_result.position};
  assign m_axis_tlast  = out_result.last;

  // The count never passes the weight.
  assert property (@(posedge clk) disable iff (rst)
    status.count <= fwss_pkg::COUNT_W'(WEIGHT))
    else $error("accepted count exceeds weight");

  // Emitting the last position closes the vector.
  assert property (@(posedge clk) disable iff (rst)
    fire && emit && result.last |=> status.done)
    else $error("vector not closed after last position");

  // A closed vector gives no result until a start request.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && status.done && !in_start |-> !emit)
    else $error("result after vector completion");

endmodule

### rtl/fwss_core.sv
// ----------------------------------------------------------------------------
// Fixed-weight sign sampler core
// Holds the occupancy bitmap, sign store and counters, and decides in one
// pass whether the presented byte is loaded, skipped or emitted.
// ----------------------------------------------------------------------------
module fwss_core #(
  parameter int unsigned WEIGHT = fwss_pkg::WEIGHT_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [fwss_pkg::BYTE_W-1:0]   rand_byte,
  input  logic                          start_req,
  output logic                          emit,
  output fwss_pkg::result_t             result,
  output fwss_pkg::status_t             status
);

  localparam int unsigned SIGN_BYTES = (WEIGHT >> 3) + 1;
  localparam int unsigned SIGN_IDX_W = (SIGN_BYTES > 1) ? $clog2(SIGN_BYTES) : 1;
  localparam int unsigned SIGN_CNT_W = $clog2(SIGN_BYTES + 1);
  localparam int unsigned CNT_HI_W   = fwss_pkg::COUNT_W - 3;

  logic [fwss_pkg::NUM_POS-1:0]  occupied_map;
  logic [fwss_pkg::BYTE_W-1:0]   sign_store [SIGN_BYTES];
  logic [SIGN_CNT_W-1:0]         sign_bytes_loaded;
  logic [fwss_pkg::COUNT_W-1:0]  accepted_count;
  logic                          vector_done;

  logic                          eff_done;
  logic [SIGN_CNT_W-1:0]         eff_loaded;
  logic [fwss_pkg::COUNT_W-1:0]  eff_count;
  logic                          occupied;
  logic                          loading;
  logic [CNT_HI_W-1:0]           count_hi;
  logic [SIGN_IDX_W-1:0]         rd_idx;
  logic [fwss_pkg::BYTE_W-1:0]   sign_byte;
  logic                          sign_bit;
  logic [fwss_pkg::COUNT_W-1:0]  count_inc;

  // A start request clears the vector state before this byte is handled.
  always_comb begin
    eff_done   = vector_done && !start_req;
    eff_loaded = start_req ? '0 : sign_bytes_loaded;
    eff_count  = start_req ? '0 : accepted_count;
    occupied   = start_req ? 1'b0 : occupied_map[rand_byte];
    loading    = eff_loaded < SIGN_CNT_W'(SIGN_BYTES);
    emit       = !eff_done && !loading && !occupied;
  end

  // Pick the sign bit for this acceptance, most significant bit first.
  always_comb begin
    count_hi  = eff_count[fwss_pkg::COUNT_W-1:3];
    rd_idx    = (count_hi >= CNT_HI_W'(SIGN_BYTES - 1)) ? SIGN_IDX_W'(SIGN_BYTES - 1)
                                                       : count_hi[SIGN_IDX_W-1:0];
    sign_byte = sign_store[rd_idx];
    sign_bit  = sign_byte[~eff_count[2:0]];
    count_inc = eff_count + 1'b1;
  end

  // Result word for an accepted position.
  always_comb begin
    result.position    = rand_byte;
    result.coefficient = sign_bit ? fwss_pkg::COEF_PLUS : fwss_pkg::COEF_MINUS;
    result.last        = (count_inc == fwss_pkg::COUNT_W'(WEIGHT));
  end

  assign status.done  = vector_done;
  assign status.count = accepted_count;

  // Bitmap and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied_map      <= '0;
      sign_bytes_loaded <= '0;
      accepted_count    <= '0;
      vector_done       <= 1'b0;
    end else if (step) begin
      if (start_req) begin
        occupied_map <= '0;
      end
      if (emit) begin
        occupied_map[rand_byte] <= 1'b1;
      end
      if (!eff_done && loading) begin
        sign_bytes_loaded <= SIGN_CNT_W'(eff_loaded + 1'b1);
      end else begin
        sign_bytes_loaded <= eff_loaded;
      end
      accepted_count <= emit ? count_inc : eff_count;
      vector_done    <= eff_done || (emit && result.last);
    end
  end

  // Sign store is written before it is read, so it needs no reset.
  always_ff @(posedge clk) begin
    if (step && !eff_done && loading) begin
      sign_store[eff_loaded[SIGN_IDX_W-1:0]] <= rand_byte;
    end
  end

endmodule
